// ----- rtl/ppghb_pkg.sv -----
package ppghb_pkg;

    localparam int SAMPLE_W = 18;
    localparam int BRIGHT_W = 16;
    localparam int DUTY_W   = 7;
    localparam int PROD_W   = 35;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [BRIGHT_W-1:0] bright_t;
    typedef logic [DUTY_W-1:0]   duty_t;
    typedef logic [PROD_W-1:0]   prod_t;

    localparam sample_t SAMPLE_MAX   = 18'h3FFFF;
    localparam sample_t THRESH_RESET = 18'd50000;
    localparam bright_t BRIGHT_MAX   = 16'd65280;

endpackage

// ----- rtl/ppghb_div.sv -----
module ppghb_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ppghb_pkg::prod_t   dividend,
    input  ppghb_pkg::sample_t divisor,
    output logic              done,
    output ppghb_pkg::prod_t   quotient
);
    import ppghb_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PROD_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    sample_t          div_reg;
    sample_t          rem_reg;
    prod_t            quo_reg;

    logic [SAMPLE_W:0] rem_sh;
    logic [SAMPLE_W:0] rem_diff;
    logic              fits;

    // One quotient bit per cycle, restoring form
    assign rem_sh   = {rem_reg, quo_reg[PROD_W-1]};
    assign rem_diff = rem_sh - {1'b0, div_reg};
    assign fits     = (rem_sh >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_diff[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/ppg_heartbeat_led_brightness_top.sv -----
// A beat whose step needs no division runs S_PREP, S_MUL, S_APPLY, then S_OUT;
// for the scaled step the 35-step serial divider runs in S_DIV before S_APPLY.
// A full batch adds a store scan before S_OUT, one entry per cycle through the single
// read port; a finger-absent beat skips the step and goes from S_PREP to the scan.
// One beat in flight; the next is taken once the result is in the output register.
// Reset: range empty, brightness 0, threshold 50000; unwritten entries read as zero.
module ppg_heartbeat_led_brightness_top
#(
    parameter int BATCH_LENGTH = 100
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  ppghb_pkg::sample_t cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  ppghb_pkg::sample_t red_sample,
    input  ppghb_pkg::sample_t ir_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output ppghb_pkg::duty_t   duty_percent,
    output logic               duty_updated,
    output logic               finger_on,
    output logic               batch_end
);
    import ppghb_pkg::*;

    localparam int SLOT_W = $clog2(BATCH_LENGTH);
    localparam int FILL_W = $clog2(BATCH_LENGTH + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BATCH_LENGTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV,
        S_APPLY,
        S_SCAN,
        S_SCAN_TAIL,
        S_OUT
    } state_t;

    state_t             state_reg;
    sample_t            thr_reg;
    sample_t            red_reg;
    logic               present_reg;
    sample_t            prev_reg;
    bright_t            bright_reg;
    sample_t            range_low_reg;
    sample_t            range_high_reg;
    logic               finger_reg;
    logic               updated_reg;
    logic               ended_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [FILL_W-1:0]  fill_reg;
    sample_t            d_reg;
    logic               rising_reg;
    bright_t            step_reg;
    logic [SLOT_W-1:0]  scan_idx_reg;
    logic               scan_vld_reg;
    logic               rd_zero_reg;
    sample_t            rd_data_reg;
    sample_t            lo_acc_reg;
    sample_t            hi_acc_reg;
    logic               out_valid_reg;
    duty_t              duty_reg;
    logic               duty_updated_reg;
    logic               finger_out_reg;
    logic               batch_end_reg;

    sample_t            store_mem [BATCH_LENGTH];

    logic               in_accept;
    logic               rising;
    sample_t            diff;
    logic [SAMPLE_W+8:0] scaled;
    prod_t              product;
    sample_t            span;
    logic               div_start;
    logic               div_done;
    prod_t              quot;
    bright_t            quot_sat;
    bright_t            bright_dn;
    logic [BRIGHT_W:0]  bright_sum;
    bright_t            bright_up;
    sample_t            rd_val;
    sample_t            lo_next;
    sample_t            hi_next;
    logic [22:0]        pct;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign rising = (red_reg > prev_reg);
    assign diff   = rising ? (red_reg - prev_reg) : (prev_reg - red_reg);

    // d * 510 * 256 as (d*512 - d*2) * 256
    assign scaled  = {d_reg, 9'b0} - {8'b0, d_reg, 1'b0};
    assign product = {scaled, 8'b0};
    assign span    = range_high_reg - range_low_reg;

    assign div_start = (state_reg == S_MUL) && (d_reg != '0)
                       && (range_high_reg > range_low_reg);

    ppghb_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (span),
        .done     (div_done),
        .quotient (quot)
    );

    // Any step at or above full scale saturates either way
    assign quot_sat = (quot > PROD_W'(BRIGHT_MAX)) ? BRIGHT_MAX : quot[BRIGHT_W-1:0];

    assign bright_dn  = (step_reg >= bright_reg) ? '0 : (bright_reg - step_reg);
    assign bright_sum = {1'b0, bright_reg} + {1'b0, step_reg};
    assign bright_up  = (bright_sum > {1'b0, BRIGHT_MAX}) ? BRIGHT_MAX
                                                          : bright_sum[BRIGHT_W-1:0];

    assign rd_val  = rd_zero_reg ? '0 : rd_data_reg;
    assign lo_next = (scan_vld_reg && (rd_val < lo_acc_reg)) ? rd_val : lo_acc_reg;
    assign hi_next = (scan_vld_reg && (rd_val > hi_acc_reg)) ? rd_val : hi_acc_reg;

    // brightness * 100 as *64 + *32 + *4
    assign pct = {1'b0, bright_reg, 6'b0} + {2'b0, bright_reg, 5'b0}
               + {5'b0, bright_reg, 2'b0};

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            store_mem[slot_reg] <= red_sample;
        end
        rd_data_reg <= store_mem[scan_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            thr_reg        <= THRESH_RESET;
            prev_reg       <= '0;
            bright_reg     <= '0;
            range_low_reg  <= SAMPLE_MAX;
            range_high_reg <= '0;
            finger_reg     <= 1'b0;
            slot_reg       <= '0;
            fill_reg       <= '0;
            scan_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            // S_OUT reloads the output register itself
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            scan_vld_reg <= (state_reg == S_SCAN);
            rd_zero_reg  <= (FILL_W'(scan_idx_reg) >= fill_reg);

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        red_reg     <= red_sample;
                        present_reg <= (ir_sample >= thr_reg);
                        if (FILL_W'(slot_reg) == fill_reg)
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    if (!present_reg)
                    begin
                        // finger absent: hold brightness, end the batch
                        finger_reg   <= 1'b0;
                        updated_reg  <= 1'b0;
                        ended_reg    <= 1'b1;
                        scan_idx_reg <= '0;
                        lo_acc_reg   <= SAMPLE_MAX;
                        hi_acc_reg   <= '0;
                        state_reg    <= S_SCAN;
                    end
                    else
                    begin
                        finger_reg  <= 1'b1;
                        updated_reg <= 1'b1;
                        d_reg       <= diff;
                        rising_reg  <= rising;
                        state_reg   <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (div_start)
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        if ((d_reg == '0) || (range_high_reg < range_low_reg))
                        begin
                            step_reg <= '0;
                        end
                        else
                        begin
                            step_reg <= BRIGHT_MAX;
                        end
                        state_reg <= S_APPLY;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        step_reg  <= quot_sat;
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    bright_reg <= rising_reg ? bright_dn : bright_up;
                    prev_reg   <= red_reg;
                    if (slot_reg == LAST_SLOT)
                    begin
                        ended_reg    <= 1'b1;
                        scan_idx_reg <= '0;
                        lo_acc_reg   <= SAMPLE_MAX;
                        hi_acc_reg   <= '0;
                        state_reg    <= S_SCAN;
                    end
                    else
                    begin
                        ended_reg <= 1'b0;
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_SCAN:
                begin
                    lo_acc_reg <= lo_next;
                    hi_acc_reg <= hi_next;
                    if (scan_idx_reg == LAST_SLOT)
                    begin
                        state_reg <= S_SCAN_TAIL;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                S_SCAN_TAIL:
                begin
                    // fold the last entry and commit the new range
                    range_low_reg  <= lo_next;
                    range_high_reg <= hi_next;
                    slot_reg       <= '0;
                    state_reg      <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg    <= 1'b1;
                        duty_reg         <= pct[22:16];
                        duty_updated_reg <= updated_reg;
                        finger_out_reg   <= finger_reg;
                        batch_end_reg    <= ended_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign duty_percent = duty_reg;
    assign duty_updated = duty_updated_reg;
    assign finger_on    = finger_out_reg;
    assign batch_end    = batch_end_reg;

`ifndef NO_ASSERTIONS
    a_bright_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bright_reg <= BRIGHT_MAX)
        else $error("brightness above full scale");

    a_slot_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (FILL_W'(slot_reg) <= fill_reg) && (fill_reg <= FILL_W'(BATCH_LENGTH)))
        else $error("write slot beyond fill count");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_TAIL) |=> (range_high_reg >= range_low_reg))
        else $error("scan committed an inverted range");
`endif

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ppghb_pkg::*;

    localparam int BATCH     = 100;
    localparam int WATCHDOG  = 3000;
    localparam int SETTLE    = 8;
    localparam int TAIL      = 160;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        duty_t duty;
        logic  updated;
        logic  present;
        logic  ended;
    } duty_beat_t;

    logic    clk;
    logic    rst_n      = 1'b0;
    logic    cfg_valid  = 1'b0;
    logic    cfg_ready;
    sample_t cfg_data   = '0;
    logic    in_valid   = 1'b0;
    logic    in_stall;
    sample_t red_sample = '0;
    sample_t ir_sample  = '0;
    logic    out_valid;
    logic    out_stall  = 1'b0;
    duty_t   duty_percent;
    logic    duty_updated;
    logic    finger_on;
    logic    batch_end;

    // tracker state mirrored on the bench side
    sample_t         sample_mem [BATCH];
    int              write_slot;
    sample_t         prev_red;
    sample_t         range_lo;
    sample_t         range_hi;
    sample_t         ir_thresh;
    longint unsigned brightness;
    logic            finger;

    duty_beat_t duty_q[$];

    int  errors       = 0;
    int  n_items      = 0;
    int  n_results    = 0;
    int  n_aborts     = 0;
    int  n_batch_ends = 0;
    int  n_flat_steps = 0;
    int  quiet_cycles = 0;

    bit  idle_on      = 1'b1;
    int  hold_request = 0;
    int  hold_left    = 0;
    int  burst_left   = 0;

    int  walk_red     = 0;
    int  walk_span    = 40;
    int  walk_spans [5] = '{0, 3, 40, 700, 20000};

    ppg_heartbeat_led_brightness_top #(.BATCH_LENGTH(BATCH)) DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red_sample   (red_sample),
        .ir_sample    (ir_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .duty_percent (duty_percent),
        .duty_updated (duty_updated),
        .finger_on    (finger_on),
        .batch_end    (batch_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Next expected result for one accepted beat; advances the mirrored state.
    function automatic void track_sample(input sample_t red, input sample_t ir,
                                         output duty_beat_t res);
        longint unsigned diff;
        longint unsigned step;
        longint unsigned sum;
        bit              rising;
        sample_t         lo;
        sample_t         hi;

        res = '0;
        if (write_slot >= BATCH)
            write_slot = 0;
        sample_mem[write_slot] = red;

        if (ir < ir_thresh)
        begin
            finger = 1'b0;
            res.ended = 1'b1;
            n_aborts++;
        end
        else
        begin
            finger = 1'b1;
            rising = red > prev_red;
            diff = rising ? 64'(red - prev_red) : 64'(prev_red - red);
            if (diff == 0 || range_hi < range_lo)
                step = 0;
            else if (range_hi == range_lo)
            begin
                step = 64'(BRIGHT_MAX);
                n_flat_steps++;
            end
            else
                step = diff * 510 * 256 / 64'(range_hi - range_lo);

            if (rising)
                brightness = (step >= brightness) ? 0 : brightness - step;
            else
            begin
                sum = brightness + step;
                brightness = (sum > BRIGHT_MAX) ? 64'(BRIGHT_MAX) : sum;
            end
            prev_red = red;
            res.updated = 1'b1;
            write_slot++;
            if (write_slot >= BATCH)
                res.ended = 1'b1;
        end

        if (res.ended)
        begin
            lo = SAMPLE_MAX;
            hi = '0;
            for (int k = 0; k < BATCH; k++)
            begin
                if (sample_mem[k] < lo) lo = sample_mem[k];
                if (sample_mem[k] > hi) hi = sample_mem[k];
            end
            range_lo = lo;
            range_hi = hi;
            write_slot = 0;
            n_batch_ends++;
        end

        res.present = finger;
        res.duty = duty_t'((brightness * 100) >> 16);
    endfunction

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    function automatic sample_t walk_next();
        int v;
        v = walk_red + int'($urandom_range(0, 2 * walk_span)) - walk_span;
        if (v < 0) v = 0;
        if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
        walk_red = v;
        return sample_t'(v);
    endfunction

    function automatic sample_t present_ir();
        return sample_t'($urandom_range(ir_thresh, SAMPLE_MAX));
    endfunction

    function automatic sample_t absent_ir();
        if (ir_thresh == 0)
            return sample_t'($urandom_range(0, SAMPLE_MAX));
        return sample_t'($urandom_range(0, ir_thresh - 1));
    endfunction

    // Offer one beat, hold it until taken, then queue what it should produce.
    task automatic send_sample(input sample_t red, input sample_t ir);
        duty_beat_t want;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        red_sample <= red;
        ir_sample  <= ir;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_sample(red, ir, want);
        duty_q.push_back(want);
        n_items++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (duty_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_threshold(input sample_t value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        ir_thresh = value;
    endtask

    // Mostly complete batches of a wandering red signal; the rest are noisy
    // beats cut short by a missing finger.
    task automatic send_batches(input int count);
        int sent;
        int n;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                walk_red  = $urandom_range(0, SAMPLE_MAX);
                walk_span = walk_spans[$urandom_range(0, 4)];
            end
            if ($urandom_range(0, 3) != 0)
            begin
                n = BATCH - write_slot;
                repeat (n) send_sample(walk_next(), present_ir());
                sent += n;
            end
            else
            begin
                n = $urandom_range(0, 30);
                repeat (n) send_sample(sample_t'($urandom_range(0, SAMPLE_MAX)), present_ir());
                send_sample(walk_next(), absent_ir());
                sent += n + 1;
            end
        end
    endtask

    task automatic test_directed();
        idle_on = 1'b1;
        // no valid range yet: steps are zero
        send_sample(18'd1000, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, THRESH_RESET);
        send_sample('0, 18'd60000);
        send_sample('0, 18'd60000);
        // finger lost just below the threshold, then with no light at all
        send_sample(SAMPLE_MAX, sample_t'(THRESH_RESET - 1));
        send_sample('0, '0);
        send_sample(18'd131071, SAMPLE_MAX);
        send_sample('0, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, SAMPLE_MAX);
        send_sample('0, SAMPLE_MAX);
        send_sample(18'd1, SAMPLE_MAX);
        send_sample(18'h2AAAA, 18'h15555);
        send_sample(18'h15555, 18'h2AAAA);
        send_sample(18'h15555, 18'h2AAAA);
        drain_results();
    endtask

    // A full batch of one value leaves a zero range: any move saturates.
    task automatic test_flat_batch();
        sample_t level;
        level = sample_t'($urandom_range(1000, SAMPLE_MAX - 1000));
        send_sample(level, absent_ir());
        repeat (BATCH) send_sample(level, present_ir());
        send_sample(sample_t'(level + 5), present_ir());
        send_sample(level, present_ir());
        send_sample(level, present_ir());
        send_sample(sample_t'(level - 1), present_ir());
        send_sample(sample_t'(level + 1), present_ir());
        send_sample(level, absent_ir());
        drain_results();
    endtask

    task automatic test_threshold_sweep();
        sample_t settings [5];
        settings[0] = '0;
        settings[1] = SAMPLE_MAX;
        settings[2] = sample_t'($urandom_range(0, SAMPLE_MAX));
        settings[3] = sample_t'($urandom_range(1, 4000));
        settings[4] = THRESH_RESET;
        foreach (settings[i])
        begin
            set_threshold(settings[i]);
            idle_on = ($urandom_range(0, 1) == 1);
            send_batches(180);
            drain_results();
        end
    endtask

    // Receiver holds off for a long stretch while beats keep being offered.
    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_request = LONG_HOLD;
        send_batches(40);
        drain_results();
    endtask

    task automatic test_random_traffic();
        idle_on = 1'b1;
        set_threshold(sample_t'($urandom_range(20000, 120000)));
        send_batches(500);
        drain_results();
        idle_on = 1'b0;
        set_threshold(sample_t'($urandom_range(20000, 120000)));
        send_batches(200);
        drain_results();
    endtask

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (burst_left > 0)
        begin
            burst_left--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            burst_left = $urandom_range(0, 7);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        duty_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (duty_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: duty %0d", $time, duty_percent);
                errors++;
            end
            else
            begin
                want = duty_q.pop_front();
                check_field("duty_percent", 32'(want.duty), 32'(duty_percent));
                check_field("duty_updated", 32'(want.updated), 32'(duty_updated));
                check_field("finger_on", 32'(want.present), 32'(finger_on));
                check_field("batch_end", 32'(want.ended), 32'(batch_end));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG, duty_q.size());
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        foreach (sample_mem[k])
            sample_mem[k] = '0;
        write_slot = 0;
        prev_red   = '0;
        range_lo   = SAMPLE_MAX;
        range_hi   = '0;
        ir_thresh  = THRESH_RESET;
        brightness = 0;
        finger     = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_flat_batch();
        test_threshold_sweep();
        test_backpressure();
        test_random_traffic();

        repeat (TAIL) @(posedge clk);
        if (duty_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, duty_q.size());
            errors++;
        end
        $display("Sent %0d samples, checked %0d results: %0d batch ends, %0d finger-absent aborts,",
                 n_items, n_results, n_batch_ends, n_aborts);
        $display("%0d saturating steps on a zero range, 7 threshold settings, %0d mismatches.",
                 n_flat_steps, errors);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ppghb_pkg.sv
rtl/ppghb_div.sv
rtl/ppg_heartbeat_led_brightness_top.sv
bench/tb_top.sv
